FILE: sv/ste_pkg.sv
// Package for the sorted table engine: command and status codes, shared types.
// Used by ste_cmp, sorted_table_engine_core and the testbench; depends on nothing.
package ste_pkg;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_FIND   = 3'd1;
   localparam logic [2:0] KIND_REMOVE = 3'd2;
   localparam logic [2:0] KIND_CLEAR  = 3'd3;
   localparam logic [2:0] KIND_DUMP   = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   // A dump never emits more items than this.
   localparam int MAX_DUMP = 16;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_result_type;

endpackage

FILE: sv/sorted_table_engine_core.sv
// Sorted table engine: sequencer over one entry memory and one shared comparator.
// A scan step reads an entry and then compares it; a shift step reads an entry and then
// writes it one place on. A dump reads and then emits each item; clear and rejected
// commands never leave idle, so busy stays low for them.
// busy stays high until the last item of a command is issued; results cannot be stalled.
// Synchronous reset empties the table; entry contents are not cleared.
module sorted_table_engine_core
   import ste_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic [3:0]         rsp_position,
   output logic signed [31:0] rsp_entry_value,
   output logic [4:0]         rsp_fill_count,
   output logic               rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;
   localparam logic [3:0] S_SCAN_CMP = 4'd2;
   localparam logic [3:0] S_INS_RD   = 4'd3;
   localparam logic [3:0] S_INS_WR   = 4'd4;
   localparam logic [3:0] S_DEL_RD   = 4'd5;
   localparam logic [3:0] S_DEL_WR   = 4'd6;
   localparam logic [3:0] S_DUMP_RD  = 4'd7;
   localparam logic [3:0] S_DUMP_EM  = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [2:0]         kind_ff, kind_in;
   logic [31:0]        value_ff, value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [3:0]         rsp_position_ff, rsp_position_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;
   logic [4:0]         rsp_fill_ff, rsp_fill_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [31:0]        mem_wd;
   logic [AW-1:0]      mem_ra;
   logic [31:0]        mem_rd;
   cmp_result_type     cmp;
   logic               scan_end;
   logic               dump_last;

   ste_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   ste_cmp u_cmp (
      .entry  (mem_rd),
      .key    (value_ff),
      .result (cmp)
   );

   assign scan_end  = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign dump_last = scan_end || (32'(idx_ff) == 32'(MAX_DUMP - 1));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      ptr_in          = ptr_ff;
      kind_in         = kind_ff;
      value_in        = value_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = STATUS_OK;
      rsp_found_in    = 1'b0;
      rsp_position_in = '0;
      rsp_value_in    = '0;
      rsp_last_in     = 1'b1;
      mem_we          = 1'b0;
      mem_wa          = ptr_ff;
      mem_wd          = mem_rd;
      mem_ra          = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               value_in = req_value;
               idx_in   = '0;
               ptr_in   = '0;
               case (req_kind)
                  KIND_INSERT: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = S_INS_RD;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  KIND_FIND, KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  KIND_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            mem_ra   = idx_ff;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (kind_ff == KIND_INSERT) begin
               // The insertion point is the first entry not below the new value.
               if (cmp.lt) begin
                  idx_in = idx_ff + AW'(1);
                  if (scan_end) begin
                     ptr_in   = AW'(count_ff);
                     state_in = S_INS_RD;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end else begin
                  ptr_in   = AW'(count_ff);
                  state_in = S_INS_RD;
               end
            end else if (cmp.eq) begin
               if (kind_ff == KIND_FIND) begin
                  rsp_valid_in    = 1'b1;
                  rsp_found_in    = 1'b1;
                  rsp_position_in = 4'(idx_ff);
                  rsp_value_in    = value_ff;
                  state_in        = S_IDLE;
               end else begin
                  ptr_in   = idx_ff;
                  state_in = S_DEL_RD;
               end
            end else if (scan_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_INS_RD: begin
            // Entries above the insertion point move up one place, top first.
            if (ptr_ff == idx_ff) begin
               mem_we          = 1'b1;
               mem_wa          = idx_ff;
               mem_wd          = value_ff;
               count_in        = count_ff + CW'(1);
               rsp_valid_in    = 1'b1;
               rsp_position_in = 4'(idx_ff);
               rsp_value_in    = value_ff;
               state_in        = S_IDLE;
            end else begin
               mem_ra   = ptr_ff - AW'(1);
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            mem_we   = 1'b1;
            mem_wa   = ptr_ff;
            mem_wd   = mem_rd;
            ptr_in   = ptr_ff - AW'(1);
            state_in = S_INS_RD;
         end
         S_DEL_RD: begin
            if ((CW'(ptr_ff) + CW'(1)) >= count_ff) begin
               count_in        = count_ff - CW'(1);
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = 4'(idx_ff);
               rsp_value_in    = value_ff;
               state_in        = S_IDLE;
            end else begin
               mem_ra   = ptr_ff + AW'(1);
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            mem_we   = 1'b1;
            mem_wa   = ptr_ff;
            mem_wd   = mem_rd;
            ptr_in   = ptr_ff + AW'(1);
            state_in = S_DEL_RD;
         end
         S_DUMP_RD: begin
            mem_ra   = idx_ff;
            state_in = S_DUMP_EM;
         end
         S_DUMP_EM: begin
            rsp_valid_in    = 1'b1;
            rsp_position_in = 4'(idx_ff);
            rsp_value_in    = mem_rd;
            rsp_last_in     = dump_last;
            idx_in          = idx_ff + AW'(1);
            state_in        = dump_last ? S_IDLE : S_DUMP_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_fill_in = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      ptr_ff          <= ptr_in;
      kind_ff         <= kind_in;
      value_ff        <= value_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_fill_ff     <= rsp_fill_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_fill_count  = rsp_fill_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds table depth");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_INSERT && count_ff == CW'(DEPTH))
      |=> (rsp_valid && rsp_status == STATUS_FULL && count_ff == CW'(DEPTH)))
      else $error("insert into a full table not rejected");

   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == S_DUMP_RD))
      else $error("non-final item issued outside a dump");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff) && count_ff != '0)
      |-> (count_ff == $past(count_ff) + CW'(1) || count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count changed by more than one");
`endif

endmodule

FILE: sv/ste_mem.sv
// Entry store of the sorted table engine: one write port, one read port,
// registered read data. Depends on nothing.
module ste_mem #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [31:0]                wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [31:0]                rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ste_cmp.sv
// Shared signed comparator of the sorted table engine, used on every scan step.
// Depends on ste_pkg.
module ste_cmp
   import ste_pkg::*;
(
   input  logic signed [31:0] entry,
   input  logic signed [31:0] key,
   output cmp_result_type     result
);

   always_comb begin
      result.lt = entry < key;
      result.eq = entry == key;
   end

endmodule

FILE: tb/ste_table_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted table engine: watches the command and result ports, keeps its
// own copy of the table, predicts every result item and compares. Depends on ste_pkg.
module ste_table_checker
   import ste_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_found,
   input  logic [3:0]         rsp_position,
   input  logic signed [31:0] rsp_entry_value,
   input  logic [4:0]         rsp_fill_count,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [3:0]         position;
      logic signed [31:0] entry_value;
      logic [4:0]         fill_count;
      logic               last;
   } reply_type;

   logic signed [31:0] table_copy [DEPTH];
   int                 table_fill;
   reply_type          expected_replies [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      table_fill = 0;
   end

   task automatic push_reply(input logic [1:0] status, input logic found,
                             input int position, input logic signed [31:0] value,
                             input logic last);
      reply_type r;
      r.status      = status;
      r.found       = found;
      r.position    = position[3:0];
      r.entry_value = value;
      r.fill_count  = table_fill[4:0];
      r.last        = last;
      expected_replies.push_back(r);
   endtask

   // Lowest index holding the value, or the fill level when it is absent.
   function automatic int lowest_match(input logic signed [31:0] value);
      for (int i = 0; i < table_fill; i++)
         if (table_copy[i] == value) return i;
      return table_fill;
   endfunction

   task automatic predict_table_command(input logic [2:0] kind,
                                        input logic signed [31:0] value);
      int p;
      int n;
      case (kind)
         KIND_INSERT: begin
            if (table_fill >= DEPTH) begin
               push_reply(STATUS_FULL, 1'b0, 0, 32'sd0, 1'b1);
            end else begin
               p = 0;
               while (p < table_fill && table_copy[p] < value) p++;
               for (int i = table_fill; i > p; i--) table_copy[i] = table_copy[i - 1];
               table_copy[p] = value;
               table_fill++;
               push_reply(STATUS_OK, 1'b0, p, value, 1'b1);
            end
         end
         KIND_FIND: begin
            p = lowest_match(value);
            if (p >= table_fill) push_reply(STATUS_NOT_FOUND, 1'b0, 0, 32'sd0, 1'b1);
            else push_reply(STATUS_OK, 1'b1, p, value, 1'b1);
         end
         KIND_REMOVE: begin
            p = lowest_match(value);
            if (p >= table_fill) begin
               push_reply(STATUS_NOT_FOUND, 1'b0, 0, 32'sd0, 1'b1);
            end else begin
               for (int i = p; i + 1 < table_fill; i++) table_copy[i] = table_copy[i + 1];
               table_fill--;
               push_reply(STATUS_OK, 1'b1, p, value, 1'b1);
            end
         end
         KIND_CLEAR: begin
            table_fill = 0;
            push_reply(STATUS_OK, 1'b0, 0, 32'sd0, 1'b1);
         end
         KIND_DUMP: begin
            n = (table_fill > MAX_DUMP) ? MAX_DUMP : table_fill;
            if (n == 0) push_reply(STATUS_EMPTY, 1'b0, 0, 32'sd0, 1'b1);
            for (int i = 0; i < n; i++)
               push_reply(STATUS_OK, 1'b0, i, table_copy[i], i + 1 == n);
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, actual %0h", $realtime, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         expected_replies.delete();
         table_fill = 0;
      end else begin
         // Results are checked before the new command is predicted: an item accepted
         // at this edge cannot have produced a result yet.
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual status %0d value %0h",
                        $realtime, rsp_status, rsp_entry_value);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               compare_field("status", want.status, rsp_status);
               compare_field("found", want.found, rsp_found);
               compare_field("position", want.position, rsp_position);
               compare_field("entry_value", want.entry_value, rsp_entry_value);
               compare_field("fill_count", want.fill_count, rsp_fill_count);
               compare_field("last", want.last, rsp_last);
            end
         end
         if (start && !busy) predict_table_command(req_kind, req_value);
      end
      pending = expected_replies.size();
   end

endmodule

FILE: tb/sorted_table_engine_core_test.sv
`timescale 1ns / 1ps
// Top of the sorted table engine testbench: clock, reset, directed and random commands
// and the verdict. Depends on ste_pkg, sorted_table_engine_core and ste_table_checker.
module sorted_table_engine_core_test
   import ste_pkg::*;
;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 4 * DEPTH + 8;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_kind = KIND_INSERT;
   logic signed [31:0] req_value = 32'sd0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic               rsp_found;
   logic [3:0]         rsp_position;
   logic signed [31:0] rsp_entry_value;
   logic [4:0]         rsp_fill_count;
   logic               rsp_last;
   int                 fail_count;
   int                 pending;
   int                 cycle_count = 0;
   int                 gap_max = 0;

   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   sorted_table_engine_core #(.DEPTH(DEPTH)) dut (.*);

   ste_table_checker #(.DEPTH(DEPTH)) table_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Presents one item and returns at the edge that accepts it. start stays high
   // afterwards; it drops only for the random gap of up to gap_max before the next item.
   task automatic issue(input logic [2:0] kind, input logic signed [31:0] value);
      int gap;
      gap = $urandom_range(0, gap_max);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     = 1'b1;
      req_kind  = kind;
      req_value = value;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic wait_for_results;
      @(negedge clock);
      start = 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
   endtask

   // Mostly small values so that finds and removes hit, plus the extremes and full noise.
   function automatic logic signed [31:0] pick_value;
      case ($urandom_range(0, 5))
         0:       return ($urandom_range(0, 1) != 0) ? MOST_NEGATIVE : MOST_POSITIVE;
         1:       return $urandom();
         default: return $signed($urandom_range(0, 16)) - 32'sd8;
      endcase
   endfunction

   function automatic logic [2:0] pick_kind(input int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == 0) return (roll < 90) ? KIND_INSERT : KIND_DUMP;
      if (roll < 4)  return 3'($urandom_range(5, 7));
      if (roll < 8)  return KIND_CLEAR;
      if (roll < 18) return KIND_DUMP;
      if (mode == 1) return (roll < 68) ? KIND_REMOVE : (roll < 85) ? KIND_FIND : KIND_INSERT;
      return (roll < 50) ? KIND_INSERT : (roll < 75) ? KIND_FIND : KIND_REMOVE;
   endfunction

   initial begin
      int modes [8] = '{0, 2, 1, 0, 2, 1, 2, 0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table cases, extremes, a duplicate, misses and ignored kinds.
      gap_max = 2;
      issue(KIND_DUMP, 32'sd5);
      issue(KIND_FIND, 32'sd0);
      issue(KIND_REMOVE, MOST_NEGATIVE);
      issue(KIND_INSERT, 32'sd0);
      issue(KIND_INSERT, MOST_NEGATIVE);
      issue(KIND_INSERT, MOST_POSITIVE);
      issue(KIND_INSERT, 32'sd0);
      issue(KIND_INSERT, -32'sd1);
      issue(KIND_FIND, 32'sd0);
      issue(KIND_FIND, MOST_POSITIVE);
      issue(KIND_FIND, 32'sd77);
      issue(KIND_REMOVE, 32'sd0);
      issue(KIND_REMOVE, 32'sd77);
      issue(KIND_DUMP, 32'sd0);
      issue(3'd5, 32'sd0);
      issue(3'd6, MOST_POSITIVE);
      issue(3'd7, MOST_NEGATIVE);
      issue(KIND_DUMP, -32'sd1);
      issue(KIND_CLEAR, 32'sd3);
      issue(KIND_DUMP, 32'sd0);
      wait_for_results();

      // Random phases of twenty items; fill phases run the table into its full state.
      foreach (modes[m]) begin
         gap_max = (m % 2 == 0) ? 4 : 0;
         for (int i = 0; i < 20; i++) issue(pick_kind(modes[m]), pick_value());
         if (m == 3) wait_for_results();
      end

      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
sv/ste_pkg.sv
sv/ste_mem.sv
sv/ste_cmp.sv
sv/sorted_table_engine_core.sv
tb/ste_table_checker.sv
tb/sorted_table_engine_core_test.sv
